// ===== sv/explicit_free_list_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Explicit free list allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define EFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/efl_pkg.sv =====
// ----------------------------------------------------------------------------
// Explicit free list allocator package
// Arena geometry, tag masks and request/status codes.
// ----------------------------------------------------------------------------
package efl_pkg;

  localparam int unsigned ARENA_BYTES     = 262144;
  localparam int unsigned CHUNK_BYTES     = 65536;
  localparam int unsigned MIN_BLOCK_BYTES = 32;
  localparam int unsigned TAG_BYTES       = 16;
  localparam int unsigned ARENA_WORDS     = ARENA_BYTES / 8;
  localparam int unsigned AW              = $clog2(ARENA_WORDS);
  localparam int unsigned WALK_LIMIT      = ARENA_BYTES / MIN_BLOCK_BYTES + 1;
  localparam int unsigned STEP_W          = $clog2(WALK_LIMIT);
  localparam int unsigned DW              = 32;

  localparam logic [DW-1:0] SIZE_MASK = 32'hFFFF_FFF8;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

endpackage

// ===== sv/efl_heap_mem.sv =====
// ----------------------------------------------------------------------------
// Heap word store
// Single-port synchronous arena memory addressed by byte offset; writes
// outside the arena are dropped and reads outside it return zero.
// ----------------------------------------------------------------------------
module efl_heap_mem (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  we_i,
  input  logic [efl_pkg::DW-1:0] addr_i,
  input  logic [efl_pkg::DW-1:0] wdata_i,
  output logic [efl_pkg::DW-1:0] rdata_o
);
  import efl_pkg::*;

  logic [DW-1:0] mem_q [ARENA_WORDS];
  logic [DW-1:0] rd_q;
  logic          oob_q;
  logic          in_range;
  logic [AW-1:0] idx;

  assign in_range = addr_i < DW'(ARENA_BYTES);
  assign idx      = addr_i[AW+2:3];

  always_ff @(posedge clk_i) begin
    if (en_i && in_range && we_i) begin
      mem_q[idx] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rd_q  <= mem_q[idx];
      oob_q <= !in_range;
    end
  end

  assign rdata_o = oob_q ? '0 : rd_q;

endmodule

// ===== sv/explicit_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Explicit free list allocator
// First-fit boundary-tag heap over an on-chip arena with a LIFO free list.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 32768-word arena to zero, one word per
// cycle, then writes four words of initial heap; it takes no request until
// both are done. Each request then runs through a sequencer around one
// single-port memory with registered reads, one access per cycle. How long
// a request runs depends on its kind: an accepted free depends on its merges,
// an allocate on the free-list entries passed over in the first-fit walk and
// on the split, grow and merge after it; a zero-size request is answered
// without a walk and an out-of-memory one after the walk.
// One request is in work at a time; the result waits in an output register.
module explicit_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // request_bytes[18:0], free_offset[36:19], zero pad
  input  logic [0:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status[1:0], payload_offset[19:2], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [18:0] cfg_data_i     // heap_limit_bytes
);
  import efl_pkg::*;

  localparam logic [5:0] S_CLR   = 6'd0,  S_INIT0 = 6'd1,  S_INIT1 = 6'd2,  S_INIT2 = 6'd3,
                         S_INIT3 = 6'd4,  S_IDLE  = 6'd5,  S_A0    = 6'd6,  S_W0    = 6'd7,
                         S_W1    = 6'd8,  S_W2    = 6'd9,  S_G0    = 6'd10, S_G1    = 6'd11,
                         S_P0    = 6'd12, S_P1    = 6'd13, S_P2    = 6'd14, S_P3    = 6'd15,
                         S_P4    = 6'd16, S_P5    = 6'd17, S_M0    = 6'd18, S_M1    = 6'd19,
                         S_M2    = 6'd20, S_M3    = 6'd21, S_M4    = 6'd22, S_M5    = 6'd23,
                         S_M6    = 6'd24, S_M7    = 6'd25, S_M8    = 6'd26, S_M9    = 6'd27,
                         S_M10   = 6'd28, S_M11   = 6'd29, S_M12   = 6'd30, S_T0    = 6'd31,
                         S_T1    = 6'd32, S_I0    = 6'd33, S_I1    = 6'd34, S_I2    = 6'd35,
                         S_I3    = 6'd36, S_R0    = 6'd37, S_R1    = 6'd38, S_R2    = 6'd39,
                         S_R3H   = 6'd40, S_R3T   = 6'd41, S_R3M   = 6'd42, S_R4M   = 6'd43,
                         S_R5    = 6'd44, S_R6    = 6'd45, S_F0    = 6'd46, S_F1    = 6'd47,
                         S_DONE  = 6'd48;

  logic [5:0]        state_q, state_d, ret_q, ret_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [DW-1:0]     head_q, head_d, tail_q, tail_d;
  logic              fv_q, fv_d;
  logic [18:0]       hb_q, hb_d, lim_q;
  logic [DW-1:0]     b_q, b_d, size_q, size_d, asize_q, asize_d, start_q, start_d;
  logic [DW-1:0]     tmp_q, tmp_d, tmp2_q, tmp2_d;
  logic [DW-1:0]     sub_b_q, sub_b_d, sub_size_q, sub_size_d;
  logic              sub_a_q, sub_a_d, pa_q, pa_d, na_q, na_d;
  logic              mode_free_q, mode_free_d;
  logic [18:0]       req_q, req_d;
  logic [17:0]       off_q, off_d, pay_q, pay_d;
  logic [1:0]        status_q, status_d;
  logic              m_valid_q, m_valid_d;
  logic [23:0]       m_data_q, m_data_d;

  logic          mem_en, mem_we;
  logic [DW-1:0] mem_addr, mem_wdata, rdat;

  efl_heap_mem u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rdat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    logic [DW-1:0] rest, lim, ext, hb32, sz, asz, off32;
    rest  = size_q - asize_q;
    hb32  = DW'(hb_q);
    lim   = (DW'(lim_q) < DW'(ARENA_BYTES)) ? DW'(lim_q) : DW'(ARENA_BYTES);
    ext   = (asize_q > DW'(CHUNK_BYTES)) ? asize_q : DW'(CHUNK_BYTES);
    sz    = rdat & SIZE_MASK;
    asz   = (DW'(req_q) + DW'(TAG_BYTES) + DW'(7)) & SIZE_MASK;
    off32 = DW'(off_q);

    state_d = state_q;   ret_d = ret_q;     clr_d = clr_q;       steps_d = steps_q;
    head_d = head_q;     tail_d = tail_q;   fv_d = fv_q;         hb_d = hb_q;
    b_d = b_q;           size_d = size_q;   asize_d = asize_q;   start_d = start_q;
    tmp_d = tmp_q;       tmp2_d = tmp2_q;   sub_b_d = sub_b_q;   sub_size_d = sub_size_q;
    sub_a_d = sub_a_q;   pa_d = pa_q;       na_d = na_q;         mode_free_d = mode_free_q;
    req_d = req_q;       off_d = off_q;     pay_d = pay_q;       status_d = status_q;
    m_valid_d = m_valid_q;  m_data_d = m_data_q;
    mem_en = 1'b0;  mem_we = 1'b0;  mem_addr = '0;  mem_wdata = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = {{(DW-AW-3){1'b0}}, clr_q, 3'b000};
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = S_INIT0;
      end
      S_INIT0: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = '0; mem_wdata = DW'(9);
        state_d = S_INIT1;
      end
      S_INIT1: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = DW'(8);
        mem_wdata = DW'(CHUNK_BYTES - TAG_BYTES);
        state_d = S_INIT2;
      end
      S_INIT2: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = DW'(CHUNK_BYTES - TAG_BYTES);
        mem_wdata = DW'(CHUNK_BYTES - TAG_BYTES);
        state_d = S_INIT3;
      end
      S_INIT3: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = DW'(CHUNK_BYTES - 8); mem_wdata = DW'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d       = s_axis_tdata[18:0];
          off_d       = s_axis_tdata[36:19];
          mode_free_d = (s_axis_tuser[0] == REQ_FREE);
          state_d     = (s_axis_tuser[0] == REQ_FREE) ? S_F0 : S_A0;
        end
      end
      S_A0: begin
        if (req_q == '0) begin
          status_d = ST_ZERO; pay_d = '0; state_d = S_DONE;
        end else begin
          asize_d = (asz < DW'(MIN_BLOCK_BYTES)) ? DW'(MIN_BLOCK_BYTES) : asz;
          steps_d = '0;
          b_d     = head_q;
          state_d = fv_q ? S_W0 : S_G0;
        end
      end
      S_W0: begin
        mem_en = 1'b1; mem_addr = b_q;
        state_d = S_W1;
      end
      S_W1: begin
        if (sz >= asize_q) begin
          state_d = S_P0;
        end else begin
          mem_en = 1'b1; mem_addr = b_q + DW'(8);
          state_d = S_W2;
        end
      end
      S_W2: begin
        if (!rdat[0]) begin
          state_d = S_G0;
        end else begin
          b_d = sz;
          if (steps_q == STEP_W'(WALK_LIMIT - 1)) begin
            state_d = S_G0;
          end else begin
            steps_d = steps_q + 1'b1;
            state_d = S_W0;
          end
        end
      end
      S_G0: begin
        if ((hb32 > lim) || (ext > lim - hb32)) begin
          status_d = ST_OOM; pay_d = '0; state_d = S_DONE;
        end else begin
          tmp_d = ext; b_d = hb32 - DW'(8);
          sub_b_d = hb32 - DW'(8); sub_size_d = ext; sub_a_d = 1'b0;
          ret_d = S_G1; state_d = S_T0;
        end
      end
      S_G1: begin
        hb_d = 19'(hb32 + tmp_q);
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = hb32 + tmp_q - DW'(8); mem_wdata = DW'(1);
        state_d = S_M0;
      end
      S_P0: begin
        mem_en = 1'b1; mem_addr = b_q;
        state_d = S_P1;
      end
      S_P1: begin
        size_d = sz; sub_b_d = b_q; ret_d = S_P2; state_d = S_R0;
      end
      S_P2: begin
        sub_b_d = b_q; sub_a_d = 1'b1;
        if (rest < DW'(MIN_BLOCK_BYTES)) begin
          sub_size_d = size_q; ret_d = S_P5;
        end else begin
          sub_size_d = asize_q; ret_d = S_P3;
        end
        state_d = S_T0;
      end
      S_P3: begin
        sub_b_d = b_q + asize_q; sub_size_d = rest; sub_a_d = 1'b0;
        ret_d = S_P4; state_d = S_T0;
      end
      S_P4: begin
        sub_b_d = b_q + asize_q; ret_d = S_P5; state_d = S_I0;
      end
      S_P5: begin
        status_d = ST_OK; pay_d = 18'(b_q + DW'(8)); state_d = S_DONE;
      end
      S_M0: begin
        mem_en = 1'b1; mem_addr = b_q;
        state_d = S_M1;
      end
      S_M1: begin
        size_d = sz;
        mem_en = 1'b1; mem_addr = b_q - DW'(8);
        state_d = S_M2;
      end
      S_M2: begin
        pa_d = rdat[0];
        mem_en = 1'b1; mem_addr = b_q + size_q;
        state_d = S_M3;
      end
      S_M3: begin
        na_d = rdat[0]; start_d = b_q;
        if (!rdat[0]) begin
          sub_b_d = b_q + size_q; ret_d = S_M4; state_d = S_R0;
        end else begin
          state_d = S_M6;
        end
      end
      S_M4: begin
        mem_en = 1'b1; mem_addr = b_q + size_q;
        state_d = S_M5;
      end
      S_M5: begin
        size_d = size_q + sz; state_d = S_M6;
      end
      S_M6: begin
        if (!pa_q) begin
          mem_en = 1'b1; mem_addr = b_q - DW'(8);
          state_d = S_M7;
        end else begin
          state_d = S_M10;
        end
      end
      S_M7: begin
        start_d = b_q - sz; sub_b_d = b_q - sz; ret_d = S_M8; state_d = S_R0;
      end
      S_M8: begin
        mem_en = 1'b1; mem_addr = start_q;
        state_d = S_M9;
      end
      S_M9: begin
        size_d = size_q + sz; state_d = S_M10;
      end
      S_M10: begin
        sub_b_d = start_q; sub_size_d = size_q; sub_a_d = 1'b0;
        ret_d = S_M11; state_d = S_T0;
      end
      S_M11: begin
        sub_b_d = start_q; ret_d = S_M12; state_d = S_I0;
      end
      S_M12: begin
        b_d = start_q;
        if (mode_free_q) begin
          status_d = ST_OK; pay_d = '0; state_d = S_DONE;
        end else begin
          state_d = S_P0;
        end
      end
      S_T0: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q;
        mem_wdata = sub_size_q | DW'(sub_a_q);
        state_d = S_T1;
      end
      S_T1: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q + sub_size_q - DW'(8);
        mem_wdata = sub_size_q | DW'(sub_a_q);
        state_d = ret_q;
      end
      S_I0: begin
        mem_en = 1'b1; mem_we = 1'b1;
        if (!fv_q) begin
          mem_addr = sub_b_q + DW'(8); mem_wdata = '0;
          state_d = S_I1;
        end else begin
          mem_addr = head_q + DW'(16); mem_wdata = sub_b_q | DW'(1);
          state_d = S_I2;
        end
      end
      S_I1: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q + DW'(16); mem_wdata = '0;
        head_d = sub_b_q; tail_d = sub_b_q; fv_d = 1'b1;
        state_d = ret_q;
      end
      S_I2: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q + DW'(8);
        mem_wdata = head_q | DW'(1);
        state_d = S_I3;
      end
      S_I3: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q + DW'(16); mem_wdata = '0;
        head_d = sub_b_q;
        state_d = ret_q;
      end
      S_R0: begin
        if (!fv_q) begin
          state_d = ret_q;
        end else begin
          mem_en = 1'b1; mem_addr = sub_b_q + DW'(8);
          state_d = S_R1;
        end
      end
      S_R1: begin
        tmp_d = rdat;
        mem_en = 1'b1; mem_addr = sub_b_q + DW'(16);
        state_d = S_R2;
      end
      S_R2: begin
        tmp2_d = rdat;
        if (head_q == tail_q) begin
          if (sub_b_q != head_q) begin
            state_d = ret_q;
          end else begin
            fv_d = 1'b0; state_d = S_R5;
          end
        end else if (sub_b_q == head_q) begin
          if (!tmp_q[0]) begin
            fv_d = 1'b0; state_d = S_R5;
          end else begin
            head_d = tmp_q & SIZE_MASK; state_d = S_R3H;
          end
        end else if (sub_b_q == tail_q) begin
          if (!rdat[0]) begin
            fv_d = 1'b0; state_d = S_R5;
          end else begin
            tail_d = sz; state_d = S_R3T;
          end
        end else begin
          state_d = S_R3M;
        end
      end
      S_R3H: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = head_q + DW'(16); mem_wdata = '0;
        state_d = S_R5;
      end
      S_R3T: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = tail_q + DW'(8); mem_wdata = '0;
        state_d = S_R5;
      end
      S_R3M: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = (tmp2_q & SIZE_MASK) + DW'(8);
        mem_wdata = tmp_q[0] ? ((tmp_q & SIZE_MASK) | DW'(1)) : '0;
        state_d = S_R4M;
      end
      S_R4M: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = (tmp_q & SIZE_MASK) + DW'(16);
        mem_wdata = tmp2_q[0] ? ((tmp2_q & SIZE_MASK) | DW'(1)) : '0;
        state_d = S_R5;
      end
      S_R5: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q + DW'(8); mem_wdata = '0;
        state_d = S_R6;
      end
      S_R6: begin
        mem_en = 1'b1; mem_we = 1'b1; mem_addr = sub_b_q + DW'(16); mem_wdata = '0;
        state_d = ret_q;
      end
      S_F0: begin
        status_d = ST_OK; pay_d = '0;
        if ((off_q[2:0] == 3'b000) && (off32 >= DW'(16))) begin
          b_d = off32 - DW'(8);
          mem_en = 1'b1; mem_addr = off32 - DW'(8);
          state_d = S_F1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F1: begin
        if (rdat[0] && (sz >= DW'(MIN_BLOCK_BYTES)) && (sz <= hb32 - DW'(8) - b_q) &&
            (b_q < hb32)) begin
          sub_b_d = b_q; sub_size_d = sz; sub_a_d = 1'b0;
          ret_d = S_M0; state_d = S_T0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0000, pay_q, status_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      ret_q     <= S_IDLE;
      clr_q     <= '0;
      steps_q   <= '0;
      head_q    <= DW'(8);
      tail_q    <= DW'(8);
      fv_q      <= 1'b1;
      hb_q      <= 19'(CHUNK_BYTES);
      lim_q     <= 19'(262144);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      clr_q     <= clr_d;
      steps_q   <= steps_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fv_q      <= fv_d;
      hb_q      <= hb_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_q         <= b_d;
    size_q      <= size_d;
    asize_q     <= asize_d;
    start_q     <= start_d;
    tmp_q       <= tmp_d;
    tmp2_q      <= tmp2_d;
    sub_b_q     <= sub_b_d;
    sub_size_q  <= sub_size_d;
    sub_a_q     <= sub_a_d;
    pa_q        <= pa_d;
    na_q        <= na_d;
    mode_free_q <= mode_free_d;
    req_q       <= req_d;
    off_q       <= off_d;
    pay_q       <= pay_d;
    status_q    <= status_d;
    m_data_q    <= m_data_d;
  end

`include "explicit_free_list_allocator_assert.svh"

  `EFL_ASSERT_IMP(a_brk_aligned, 1'b1, (hb_q[2:0] == 3'b000) && (DW'(hb_q) <= DW'(ARENA_BYTES)), "heap break misaligned or past arena")
  `EFL_ASSERT_IMP(a_list_aligned, fv_q, (head_q[2:0] == 3'b000) && (tail_q[2:0] == 3'b000), "free list end misaligned")
  `EFL_ASSERT_IMP(a_fail_no_pay, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK), m_axis_tdata[19:2] == '0, "failed request carries an offset")
  `EFL_ASSERT_NXT(a_clr_blocks, state_q == S_CLR, !s_axis_tready, "request taken during clear")

endmodule

// ===== tb/tb_explicit_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Explicit free list allocator testbench
// Drives allocate and free requests through the stream ports with random
// gaps and stalls, keeps its own heap image to work out each reply, and
// compares the status and payload offset of every reply against the oldest expectation.
// Also covers the heap limit register at its extremes, a long output
// hold-off that backs the block up, and the out-of-memory and bad-free cases.
// ----------------------------------------------------------------------------
module tb_explicit_free_list_allocator;
  import efl_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] offset;
  } alloc_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // request_bytes[18:0], free_offset[36:19], zero pad
  logic [0:0]  s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // status[1:0], payload_offset[19:2], zero pad
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [18:0] cfg_data_i;     // heap_limit_bytes

  explicit_free_list_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // heap image
  logic [63:0] heap_img [0:ARENA_WORDS-1];
  int unsigned fl_head, fl_tail, brk, limit_reg;
  bit          fl_valid;

  alloc_reply_t reply_q[$];
  int unsigned  live_q[$];
  int unsigned  freed_q[$];
  int           errors;
  bit           send_idle, recv_idle;
  int           hold_cycles;

  function automatic logic [63:0] heap_rd(int unsigned off);
    int unsigned i;
    i = off >> 3;
    return (i < ARENA_WORDS) ? heap_img[i] : 64'd0;
  endfunction

  function automatic void heap_wr(int unsigned off, logic [63:0] v);
    int unsigned i;
    i = off >> 3;
    if (i < ARENA_WORDS) heap_img[i] = v;
  endfunction

  function automatic int unsigned blk_size(int unsigned b);
    logic [63:0] w;
    w = heap_rd(b);
    return w[31:0] & SIZE_MASK;
  endfunction

  function automatic bit blk_used(int unsigned b);
    logic [63:0] w;
    w = heap_rd(b);
    return w[0];
  endfunction

  function automatic void set_tag(int unsigned b, int unsigned size, int unsigned a);
    heap_wr(b, {32'd0, size | a});
    heap_wr(b + size - 8, {32'd0, size | a});
  endfunction

  function automatic void link_next(int unsigned b, int unsigned n, bit v);
    heap_wr(b + 8, v ? {32'd0, n | 1} : 64'd0);
  endfunction

  function automatic void link_prev(int unsigned b, int unsigned p, bit v);
    heap_wr(b + 16, v ? {32'd0, p | 1} : 64'd0);
  endfunction

  function automatic void fl_push(int unsigned b);
    if (!fl_valid) begin
      link_next(b, 0, 0);
      link_prev(b, 0, 0);
      fl_head  = b;
      fl_tail  = b;
      fl_valid = 1;
    end else begin
      link_prev(fl_head, b, 1);
      link_next(b, fl_head, 1);
      link_prev(b, 0, 0);
      fl_head = b;
    end
  endfunction

  function automatic void fl_unlink(int unsigned b);
    logic [63:0] nx, pv;
    int unsigned p, n;
    if (!fl_valid) return;
    nx = heap_rd(b + 8);
    pv = heap_rd(b + 16);
    if (fl_head == fl_tail) begin
      if (b != fl_head) return;
      fl_valid = 0;
    end else if (b == fl_head) begin
      if (!nx[0]) fl_valid = 0;
      else begin
        fl_head = nx[31:0] & SIZE_MASK;
        link_prev(fl_head, 0, 0);
      end
    end else if (b == fl_tail) begin
      if (!pv[0]) fl_valid = 0;
      else begin
        fl_tail = pv[31:0] & SIZE_MASK;
        link_next(fl_tail, 0, 0);
      end
    end else begin
      p = pv[31:0] & SIZE_MASK;
      n = nx[31:0] & SIZE_MASK;
      link_next(p, n, nx[0]);
      link_prev(n, p, pv[0]);
    end
    link_next(b, 0, 0);
    link_prev(b, 0, 0);
  endfunction

  function automatic int unsigned coalesce(int unsigned b);
    int unsigned size, start, nb, pb;
    bit pa, na;
    logic [63:0] ft;
    size  = blk_size(b);
    pa    = blk_used(b - 8);
    na    = blk_used(b + size);
    start = b;
    if (!na) begin
      nb = b + size;
      fl_unlink(nb);
      size += blk_size(nb);
    end
    if (!pa) begin
      ft = heap_rd(b - 8);
      pb = b - (ft[31:0] & SIZE_MASK);
      fl_unlink(pb);
      size += blk_size(pb);
      start = pb;
    end
    set_tag(start, size, 0);
    fl_push(start);
    return start;
  endfunction

  function automatic void carve(int unsigned b, int unsigned asize);
    int unsigned size, rest;
    size = blk_size(b);
    rest = size - asize;
    fl_unlink(b);
    if (rest < MIN_BLOCK_BYTES) set_tag(b, size, 1);
    else begin
      set_tag(b, asize, 1);
      set_tag(b + asize, rest, 0);
      fl_push(b + asize);
    end
  endfunction

  function automatic bit first_fit(int unsigned asize, output int unsigned found);
    int unsigned b;
    logic [63:0] nx;
    b     = fl_head;
    found = 0;
    if (!fl_valid) return 0;
    for (int unsigned s = 0; s < WALK_LIMIT; s++) begin
      if (blk_size(b) >= asize) begin
        found = b;
        return 1;
      end
      nx = heap_rd(b + 8);
      if (!nx[0]) return 0;
      b = nx[31:0] & SIZE_MASK;
    end
    return 0;
  endfunction

  function automatic void heap_init();
    for (int i = 0; i < ARENA_WORDS; i++) heap_img[i] = '0;
    heap_wr(0, 64'd9);
    set_tag(8, CHUNK_BYTES - TAG_BYTES, 0);
    heap_wr(CHUNK_BYTES - 8, 64'd1);
    fl_valid = 0;
    fl_push(8);
    brk       = CHUNK_BYTES;
    limit_reg = 262144;
  endfunction

  function automatic alloc_reply_t predict_request(logic kind, logic [18:0] nbytes,
                                                   logic [17:0] foff);
    alloc_reply_t r;
    int unsigned asize, b, ext, lim, nb, off, size;
    r = '0;
    if (kind == REQ_ALLOC) begin
      if (nbytes == 0) r.status = ST_ZERO;
      else begin
        asize = ((nbytes + TAG_BYTES + 7) >> 3) << 3;
        if (asize < MIN_BLOCK_BYTES) asize = MIN_BLOCK_BYTES;
        if (first_fit(asize, b)) begin
          carve(b, asize);
          r.offset = 18'(b + 8);
        end else begin
          ext = (asize > CHUNK_BYTES) ? asize : CHUNK_BYTES;
          lim = (limit_reg < ARENA_BYTES) ? limit_reg : ARENA_BYTES;
          if (brk > lim || ext > lim - brk) r.status = ST_OOM;
          else begin
            nb = brk - 8;
            set_tag(nb, ext, 0);
            brk += ext;
            heap_wr(brk - 8, 64'd1);
            nb = coalesce(nb);
            carve(nb, asize);
            r.offset = 18'(nb + 8);
          end
        end
      end
    end else begin
      off = 32'(foff);
      if ((off & 7) == 0 && off >= 16) begin
        b    = off - 8;
        size = blk_size(b);
        if (blk_used(b) && size >= MIN_BLOCK_BYTES && brk >= 8 &&
            size <= brk - 8 - b && b < brk) begin
          set_tag(b, size, 0);
          void'(coalesce(b));
        end
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result checker
  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        $display("%0t unexpected reply: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, want.status,
                   m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[19:2] !== want.offset) begin
          $display("%0t payload_offset: expected %0d, actual %0d", $time, want.offset,
                   m_axis_tdata[19:2]);
          errors++;
        end
      end
    end
  end

  // reply sink
  initial begin
    int n;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      n = recv_idle ? $urandom_range(0, 14) : 0;
      if (n > 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_req(logic kind, logic [18:0] nbytes, logic [17:0] foff);
    int n;
    alloc_reply_t r;
    n = send_idle ? $urandom_range(0, 14) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b0, foff, nbytes};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    r = predict_request(kind, nbytes, foff);
    reply_q.push_back(r);
    if (kind == REQ_ALLOC && r.status == ST_OK) live_q.push_back(32'(r.offset));
  endtask

  task automatic alloc_req(logic [18:0] nbytes);
    send_req(REQ_ALLOC, nbytes, 18'($urandom_range(0, 262143)));
  endtask

  task automatic free_req(logic [17:0] foff);
    send_req(REQ_FREE, 19'($urandom_range(0, 524287)), foff);
  endtask

  task automatic free_live();
    int idx;
    int unsigned off;
    idx = $urandom_range(0, live_q.size() - 1);
    off = live_q[idx];
    live_q.delete(idx);
    freed_q.push_back(off);
    free_req(18'(off));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [18:0] v);
    cfg_valid_i <= 1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    limit_reg = 32'(v);
    cfg_valid_i <= 0;
  endtask

  task automatic test_directed();
    int unsigned a, b, c;
    alloc_req(0);
    alloc_req(1);
    alloc_req(8);
    alloc_req(17);
    alloc_req(19'h7FFFF);
    alloc_req(65520);
    alloc_req(200);
    alloc_req(300);
    alloc_req(100);
    a = live_q[4];
    b = live_q[5];
    c = live_q[6];
    free_req(18'd3);
    free_req(18'd0);
    free_req(18'd8);
    free_req(18'h3FFFF);
    free_req(18'h3FFF8);
    free_req(18'(a));
    free_req(18'(c));
    free_req(18'(b));
    free_req(18'(b));
    alloc_req(50);
    alloc_req(100000);
    alloc_req(262128);
    drain();
  endtask

  task automatic test_limit_extremes();
    write_limit(19'd65536);
    alloc_req(70000);
    alloc_req(40);
    drain();
    write_limit(19'h7FFFF);
    alloc_req(70000);
    drain();
    write_limit(19'd131072);
    alloc_req(70000);
    drain();
  endtask

  task automatic random_phase(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 4) alloc_req(0);
      else if (r < 7) alloc_req(19'($urandom_range(0, 524287)));
      else if (r < 11) alloc_req(19'($urandom_range(2048, 70000)));
      else if (r < 55 || live_q.size() == 0) alloc_req(19'($urandom_range(1, 300)));
      else if (r < 90) free_live();
      else if (r < 95 && freed_q.size() != 0)
        free_req(18'(freed_q[$urandom_range(0, freed_q.size() - 1)]));
      else free_req(18'($urandom_range(0, 262143)));
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 800;
    random_phase(60);
  endtask

  initial begin
    errors        = 0;
    hold_cycles   = 0;
    send_idle     = 1;
    recv_idle     = 1;
    rst_ni        = 0;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 0;
    cfg_data_i    = '0;
    heap_init();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    test_directed();
    test_limit_extremes();
    write_limit(19'd262144);
    random_phase(400);
    send_idle = 0;
    recv_idle = 0;
    random_phase(400);
    test_backpressure();
    send_idle = 1;
    recv_idle = 1;
    write_limit(19'd65536);
    random_phase(300);
    write_limit(19'd200000);
    send_idle = 0;
    random_phase(400);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/efl_pkg.sv
sv/efl_heap_mem.sv
sv/explicit_free_list_allocator.sv
tb/tb_explicit_free_list_allocator.sv
